[hdl/sta_pkg.sv]
// sta_pkg: shared constants, codes and control types for the session time accumulator
// no dependencies; imported by sta_name_table, sta_rec_table and session_time_accumulator
`timescale 1ns / 1ps
`default_nettype none

package sta_pkg;

  localparam int unsigned ENTRIES_DEF    = 32;
  localparam int unsigned NAME_BYTES_DEF = 32;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned NAME_IN_W  = 4 * WORD_W;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned TOT_W      = 64;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned IDX_OUT_W  = 5;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned IN_DATA_W  = NAME_IN_W + TS_W;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(32);

  localparam logic [KIND_W-1:0] KIND_LOGIN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOGOUT = 2'd1;

  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd5;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
  } name_ctl_t;

  typedef enum logic [2:0] {
    REC_NONE,
    REC_READ,
    REC_LOGIN,
    REC_NEW,
    REC_DELTA,
    REC_ADD
  } rec_op_e;

endpackage

`default_nettype wire

[hdl/sta_name_table.sv]
// sta_name_table: name key register with zero-termination cleanup, name memory and
// the shared key compare used by the serial scan; depends on sta_pkg
`timescale 1ns / 1ps
`default_nettype none

module sta_name_table #(
  parameter int unsigned ENTRIES    = sta_pkg::ENTRIES_DEF,
  parameter int unsigned NAME_BYTES = sta_pkg::NAME_BYTES_DEF,
  parameter int unsigned ADDR_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire                      clk_i,
  input  sta_pkg::name_ctl_t       ctl_i,
  input  wire [NAME_BYTES*8-1:0]   raw_name_i,
  input  wire [ADDR_W-1:0]         rd_addr_i,
  input  wire [ADDR_W-1:0]         wr_addr_i,
  output logic                     match_o
);
  import sta_pkg::*;

  localparam int unsigned NAME_W = NAME_BYTES * 8;

  logic [NAME_W-1:0] name_mem [ENTRIES];
  logic [NAME_W-1:0] key_q;
  logic [NAME_W-1:0] rd_q;
  logic [NAME_W-1:0] clean;
  logic              ended;

  // bytes from the first zero byte on read as zero
  always_comb begin
    ended = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (raw_name_i[8*k +: 8] == 8'h00) ended = 1'b1;
      clean[8*k +: 8] = ended ? 8'h00 : raw_name_i[8*k +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) key_q <= clean;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) name_mem[wr_addr_i] <= key_q;
    if (ctl_i.rd) rd_q <= name_mem[rd_addr_i];
  end

  assign match_o = (rd_q == key_q);

endmodule

`default_nettype wire

[hdl/sta_rec_table.sv]
// sta_rec_table: per-entry login stamp and session total memory with the shared
// 64-bit session adder; depends on sta_pkg
`timescale 1ns / 1ps
`default_nettype none

module sta_rec_table #(
  parameter int unsigned ENTRIES = sta_pkg::ENTRIES_DEF,
  parameter int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire                         clk_i,
  input  sta_pkg::rec_op_e            op_i,
  input  wire [ADDR_W-1:0]            addr_i,
  input  wire [sta_pkg::TS_W-1:0]     ts_i,
  output logic [sta_pkg::TOT_W-1:0]   total_o
);
  import sta_pkg::*;

  localparam int unsigned REC_W = TS_W + TOT_W;

  logic [REC_W-1:0] rec_mem [ENTRIES];
  logic [REC_W-1:0] rd_q;
  logic [TOT_W-1:0] delta_q;
  logic [TOT_W-1:0] total_q;
  logic [TS_W-1:0]  rd_stamp;
  logic [TOT_W-1:0] rd_total;
  logic [TS_W:0]    diff;
  logic [TOT_W-1:0] sum;

  assign rd_stamp = rd_q[REC_W-1:TOT_W];
  assign rd_total = rd_q[TOT_W-1:0];
  assign diff     = {1'b0, ts_i} - {1'b0, rd_stamp};
  assign sum      = rd_total + delta_q;

  always_ff @(posedge clk_i) begin
    case (op_i)
      REC_READ:  rd_q <= rec_mem[addr_i];
      REC_LOGIN: begin
        rec_mem[addr_i] <= {ts_i, rd_total};
        total_q         <= rd_total;
      end
      REC_NEW: begin
        rec_mem[addr_i] <= {ts_i, {TOT_W{1'b0}}};
        total_q         <= '0;
      end
      REC_DELTA: delta_q <= {{(TOT_W-TS_W-1){diff[TS_W]}}, diff};
      REC_ADD: begin
        rec_mem[addr_i] <= {rd_stamp, sum};
        total_q         <= sum;
      end
      default: ;
    endcase
  end

  assign total_o = total_q;

endmodule

`default_nettype wire

[hdl/session_time_accumulator.sv]
// session_time_accumulator: top level with the scan sequencer, entry counter, limit
// register and output register; uses sta_pkg, sta_name_table and sta_rec_table
//
// channel   dir  bits  contents
// s_axis    in   288   tdata: name_word0..3, timestamp; tuser: kind
// m_axis    out  80    tdata: entry_index, total_time, entries_used; tuser: status
// cfg       in   6     table_limit, written when cfg_we_i is high
//
// accept to next accept: scan of entries in use, S_REC on a hit, S_ADD on a logout hit, S_OUT
// other records go to S_OUT; names are read one entry per cycle, which sets the scan length
// after reset the table is empty and table_limit is 32; no clearing pass
// s_axis_tready is low while a beat is worked on; a waiting result stalls only the finish
`timescale 1ns / 1ps
`default_nettype none

module session_time_accumulator #(
  parameter int unsigned ENTRIES    = sta_pkg::ENTRIES_DEF,
  parameter int unsigned NAME_BYTES = sta_pkg::NAME_BYTES_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // name_word0, name_word1, name_word2, name_word3, timestamp
  input  wire [sta_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind
  input  wire [sta_pkg::KIND_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // entry_index, total_time, entries_used, zero fill
  output logic [sta_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status
  output logic [sta_pkg::STATUS_W-1:0]     m_axis_tuser,
  input  wire                              cfg_we_i,
  input  wire [sta_pkg::CNT_W-1:0]         cfg_wdata_i
);
  import sta_pkg::*;

  localparam int unsigned ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NAME_W = NAME_BYTES * 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_REC  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    limit_q;
  logic [CNT_W-1:0]    used_q, used_d;
  logic [CNT_W-1:0]    scan_q, scan_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [CNT_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [KIND_W-1:0]   kind_q;
  logic [TS_W-1:0]     ts_q;

  logic                out_vld_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [IDX_OUT_W-1:0] out_idx_q;
  logic [TOT_W-1:0]    out_total_q;
  logic [CNT_W-1:0]    out_used_q;

  logic [CNT_W-1:0]    limit_eff;
  logic                accept;
  logic                out_load;
  logic                has_total;
  logic                match;
  name_ctl_t           name_ctl;
  rec_op_e             rec_op;
  logic [ADDR_W-1:0]   name_rd_addr;
  logic [ADDR_W-1:0]   used_addr;
  logic [ADDR_W-1:0]   rec_addr;
  logic [TOT_W-1:0]    rec_total;

  assign limit_eff = (int'(limit_q) > ENTRIES) ? CNT_W'(ENTRIES) : limit_q;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state_q == S_OUT) && (!out_vld_q || m_axis_tready);
  assign has_total = (res_status_q == ST_NEW) || (res_status_q == ST_UPDATED) ||
                     (res_status_q == ST_ADDED);
  assign name_rd_addr = ADDR_W'(scan_q);
  assign used_addr    = ADDR_W'(used_q);

  sta_name_table #(
    .ENTRIES    (ENTRIES),
    .NAME_BYTES (NAME_BYTES),
    .ADDR_W     (ADDR_W)
  ) u_name (
    .clk_i      (clk_i),
    .ctl_i      (name_ctl),
    .raw_name_i (s_axis_tdata[NAME_W-1:0]),
    .rd_addr_i  (name_rd_addr),
    .wr_addr_i  (used_addr),
    .match_o    (match)
  );

  sta_rec_table #(
    .ENTRIES (ENTRIES),
    .ADDR_W  (ADDR_W)
  ) u_rec (
    .clk_i   (clk_i),
    .op_i    (rec_op),
    .addr_i  (rec_addr),
    .ts_i    (ts_q),
    .total_o (rec_total)
  );

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    scan_d       = scan_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    name_ctl     = '0;
    rec_op       = REC_NONE;
    rec_addr     = ADDR_W'(idx_q);
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          name_ctl.load = 1'b1;
          scan_d        = '0;
          cmp_vld_d     = 1'b0;
          idx_d         = '0;
          if (s_axis_tuser == KIND_LOGIN || s_axis_tuser == KIND_LOGOUT) begin
            state_d = S_SCAN;
          end else begin
            res_status_d = ST_IGNORED;
            state_d      = S_OUT;
          end
        end
      end
      S_SCAN: begin
        if (cmp_vld_q && match) begin
          rec_op   = REC_READ;
          rec_addr = ADDR_W'(cmp_idx_q);
          idx_d    = cmp_idx_q;
          state_d  = S_REC;
        end else if (scan_q < used_q) begin
          name_ctl.rd = 1'b1;
          cmp_vld_d   = 1'b1;
          cmp_idx_d   = scan_q;
          scan_d      = scan_q + 1'b1;
        end else if (cmp_vld_q) begin
          cmp_vld_d = 1'b0;
        end else begin
          state_d = S_OUT;
          if (kind_q == KIND_LOGOUT) begin
            res_status_d = ST_UNKNOWN;
          end else if (used_q < limit_eff) begin
            name_ctl.wr  = 1'b1;
            rec_op       = REC_NEW;
            rec_addr     = used_addr;
            idx_d        = used_q;
            used_d       = used_q + 1'b1;
            res_status_d = ST_NEW;
          end else begin
            res_status_d = ST_FULL;
          end
        end
      end
      S_REC: begin
        if (kind_q == KIND_LOGOUT) begin
          rec_op  = REC_DELTA;
          state_d = S_ADD;
        end else begin
          rec_op       = REC_LOGIN;
          res_status_d = ST_UPDATED;
          state_d      = S_OUT;
        end
      end
      S_ADD: begin
        rec_op       = REC_ADD;
        res_status_d = ST_ADDED;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      limit_q   <= LIMIT_RST;
      used_q    <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q    <= cmp_idx_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    if (accept) begin
      kind_q <= s_axis_tuser;
      ts_q   <= s_axis_tdata[NAME_IN_W +: TS_W];
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= idx_q[IDX_OUT_W-1:0];
      out_total_q  <= has_total ? rec_total : '0;
      out_used_q   <= used_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-IDX_OUT_W-TOT_W-CNT_W){1'b0}},
                          out_used_q, out_total_q, out_idx_q};

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(used_q) <= ENTRIES)
    else $error("entry count beyond table depth");

  a_used_grows_on_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (res_status_q == ST_NEW && used_q == $past(used_q) + 1'b1))
    else $error("entry count changed without a new entry");

  a_hit_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REC || state_q == S_ADD) |-> (idx_q < used_q))
    else $error("hit on an entry not in use");

  a_ignored_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser != KIND_LOGIN && s_axis_tuser != KIND_LOGOUT) |=>
    (state_q == S_OUT && res_status_q == ST_IGNORED))
    else $error("other record not passed straight to output");

endmodule

`default_nettype wire

[tb/session_time_accumulator_tb.sv]
// session_time_accumulator_tb: self-checking bench for the login session time accounting
// block; keeps its own copy of the name table and checks every result beat field by field
// depends on sta_pkg and session_time_accumulator
`timescale 1ns / 1ps

module session_time_accumulator_tb;
  import sta_pkg::*;

  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int POOL_SIZE     = 40;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [IDX_OUT_W-1:0] idx;
    logic [TOT_W-1:0]     total;
    logic [CNT_W-1:0]     used;
  } acct_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [KIND_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata_i = '0;

  // shadow of the accounting table
  logic [NAME_IN_W-1:0] stored_name [ENTRIES_DEF];
  logic [TS_W-1:0]      stamp_at [ENTRIES_DEF];
  logic [TOT_W-1:0]     sum_at [ENTRIES_DEF];
  int unsigned          rows_used = 0;
  logic [CNT_W-1:0]     limit_reg = LIMIT_RST;

  acct_result_t         pending_results [$];
  int                   mismatches = 0;
  bit                   calm = 1'b0;

  logic [NAME_IN_W-1:0] pool [POOL_SIZE];
  logic [TS_W-1:0]      pool_login [POOL_SIZE];

  session_time_accumulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // name ends at its first zero byte
  function automatic logic [NAME_IN_W-1:0] trim_name(input logic [NAME_IN_W-1:0] raw);
    logic [NAME_IN_W-1:0] r;
    bit ended;
    r = '0;
    ended = 1'b0;
    for (int k = 0; k < NAME_IN_W / 8; k++) begin
      if (raw[8*k +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[8*k +: 8] = raw[8*k +: 8];
    end
    return r;
  endfunction

  // random bytes behind the terminator, same name after trimming
  function automatic logic [NAME_IN_W-1:0] smear_tail(input logic [NAME_IN_W-1:0] raw);
    logic [NAME_IN_W-1:0] r;
    bit ended;
    r = raw;
    ended = 1'b0;
    for (int k = 0; k < NAME_IN_W / 8; k++) begin
      if (ended) r[8*k +: 8] = 8'($urandom_range(0, 255));
      else if (r[8*k +: 8] == 8'h00) ended = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [NAME_IN_W-1:0] random_name();
    logic [NAME_IN_W-1:0] r;
    int len;
    r = '0;
    len = $urandom_range(1, NAME_IN_W / 8);
    for (int k = 0; k < len; k++) r[8*k +: 8] = 8'($urandom_range(1, 255));
    return r;
  endfunction

  function automatic logic [NAME_IN_W-1:0] random_words();
    return {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  function automatic acct_result_t account_event(input logic [KIND_W-1:0] kind,
                                                 input logic [NAME_IN_W-1:0] raw,
                                                 input logic [TS_W-1:0] ts);
    acct_result_t r;
    logic [NAME_IN_W-1:0] name;
    int hit;
    int unsigned cap;
    name = trim_name(raw);
    hit = -1;
    cap = (limit_reg > ENTRIES_DEF) ? ENTRIES_DEF : limit_reg;
    r.status = ST_IGNORED;
    r.idx = '0;
    r.total = '0;
    for (int i = 0; i < rows_used; i++) begin
      if (hit < 0 && stored_name[i] == name) hit = i;
    end
    if (kind == KIND_LOGIN) begin
      if (hit >= 0) begin
        stamp_at[hit] = ts;
        r.status = ST_UPDATED;
        r.idx = hit[IDX_OUT_W-1:0];
        r.total = sum_at[hit];
      end else if (rows_used < cap) begin
        stored_name[rows_used] = name;
        stamp_at[rows_used] = ts;
        sum_at[rows_used] = '0;
        r.status = ST_NEW;
        r.idx = rows_used[IDX_OUT_W-1:0];
        r.total = '0;
        rows_used++;
      end else begin
        r.status = ST_FULL;
      end
    end else if (kind == KIND_LOGOUT) begin
      if (hit >= 0) begin
        sum_at[hit] = sum_at[hit] + {32'd0, ts} - {32'd0, stamp_at[hit]};
        r.status = ST_ADDED;
        r.idx = hit[IDX_OUT_W-1:0];
        r.total = sum_at[hit];
      end else begin
        r.status = ST_UNKNOWN;
      end
    end
    r.used = rows_used[CNT_W-1:0];
    return r;
  endfunction

  task automatic send_record(input logic [KIND_W-1:0] kind, input logic [NAME_IN_W-1:0] raw,
                             input logic [TS_W-1:0] ts);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ts, raw};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(account_event(kind, raw, ts));
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    limit_reg = value;
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  // result beat checker and random back-pressure
  always @(posedge clk_i) begin : result_check
    acct_result_t want;
    int stall_left;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none actual status %0h data %0h",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 64'(want.status), 64'(m_axis_tuser));
          compare_field("entry_index", 64'(want.idx), 64'(m_axis_tdata[IDX_OUT_W-1:0]));
          compare_field("total_time", want.total, m_axis_tdata[IDX_OUT_W +: TOT_W]);
          compare_field("entries_used", 64'(want.used),
                        64'(m_axis_tdata[IDX_OUT_W + TOT_W +: CNT_W]));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // limit zero: nothing can be added
  task automatic test_empty_limit();
    write_limit(6'd0);
    send_record(KIND_LOGIN, 256'h41, 32'd10);
    send_record(KIND_LOGOUT, 256'h41, 32'd20);
    send_record(KIND_OTHER, 256'h41, 32'd30);
    send_record(KIND_SPARE, random_words(), $urandom());
  endtask

  // one entry, table full, negative session
  task automatic test_single_entry();
    write_limit(6'd1);
    send_record(KIND_LOGIN, 256'h41, 32'hFFFF_FFFF);
    send_record(KIND_LOGIN, 256'h42, 32'd1);
    send_record(KIND_LOGOUT, 256'h41, 32'd0);
    send_record(KIND_LOGIN, 256'h41, 32'd5);
    send_record(KIND_LOGOUT, 256'h41, 32'd100);
    send_record(KIND_LOGOUT, 256'h42, 32'd200);
  endtask

  // full-length name, garbage after the terminator, empty name; limit above table size
  task automatic test_name_ends();
    write_limit(6'd63);
    send_record(KIND_LOGIN, {32{8'hFF}}, 32'd0);
    send_record(KIND_LOGOUT, {32{8'hFF}}, 32'hFFFF_FFFF);
    send_record(KIND_LOGIN, smear_tail(256'h78), 32'd1000);
    send_record(KIND_LOGOUT, smear_tail(256'h78), 32'd4000);
    send_record(KIND_LOGIN, '0, 32'h8000_0000);
    send_record(KIND_LOGOUT, smear_tail('0), 32'h8000_0123);
  endtask

  // limit below entries in use
  task automatic test_lowered_limit();
    write_limit(6'd2);
    send_record(KIND_LOGIN, 256'h7A7A, 32'd50);
    send_record(KIND_LOGIN, 256'h78, 32'd60);
    send_record(KIND_LOGOUT, 256'h78, 32'd90);
  endtask

  task automatic test_random_traffic(input logic [CNT_W-1:0] limit, input int beats);
    int r;
    int pick;
    logic [NAME_IN_W-1:0] raw;
    logic [KIND_W-1:0] kind;
    logic [TS_W-1:0] ts;
    write_limit(limit);
    for (int n = 0; n < beats; n++) begin
      if (n == beats / 2) hold_until_drained();
      r = $urandom_range(0, 99);
      pick = $urandom_range(0, POOL_SIZE - 1);
      raw = $urandom_range(0, 1) ? smear_tail(pool[pick]) : pool[pick];
      ts = $urandom();
      if (r < 45) begin
        kind = KIND_LOGIN;
        pool_login[pick] = ts;
      end else if (r < 88) begin
        kind = KIND_LOGOUT;
        if ($urandom_range(0, 19) != 0) ts = pool_login[pick] + $urandom_range(0, 200000);
      end else if (r < 95) begin
        kind = $urandom_range(0, 1) ? KIND_OTHER : KIND_SPARE;
        raw = random_words();
      end else if (r < 99) begin
        kind = KIND_LOGOUT;
        raw = random_words();
      end else begin
        kind = KIND_LOGIN;
        raw = random_words();
      end
      send_record(kind, raw, ts);
    end
  endtask

  initial begin
    logic [NAME_IN_W-1:0] fresh;
    bit clash;
    for (int p = 0; p < POOL_SIZE; p++) begin
      do begin
        fresh = random_name();
        clash = 1'b0;
        for (int q = 0; q < p; q++) if (pool[q] == fresh) clash = 1'b1;
      end while (clash);
      pool[p] = fresh;
      pool_login[p] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_limit();
    test_single_entry();
    test_name_ends();
    test_lowered_limit();
    test_random_traffic(6'd10, 350);
    test_random_traffic(6'd24, 400);
    test_random_traffic(6'd1, 200);
    test_random_traffic(6'd63, 450);
    calm = 1'b1;
    test_random_traffic(6'd32, 500);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("session_time_accumulator_tb: done, clean");
    end else begin
      $display("session_time_accumulator_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("session_time_accumulator_tb: done, errors");
    $finish;
  end

endmodule
